// ----- hw/rtl/jeo_pkg.sv -----
// ----------------------------------------------------------------------------
// jeo_pkg
// Shared constants and types for the Josephus elimination order unit.
// ----------------------------------------------------------------------------
package jeo_pkg;

  localparam int MaxPeople = 64;
  localparam int PeopleW   = 7;
  localparam int StepW     = 16;

  // Controls from the sequencer to the seat ring
  typedef struct packed {
    logic init;  // load a fresh circle, seat 0
    logic adv;   // move to the next seat
    logic kill;  // remove the person at the current seat
  } jeo_ring_ctrl_t;

endpackage

// ----- hw/rtl/jeo_if.sv -----
// ----------------------------------------------------------------------------
// jeo_in_if / jeo_out_if
// Valid/ready channels carrying the input item and the result item.
// ----------------------------------------------------------------------------
interface jeo_in_if import jeo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PeopleW-1:0] people_count;
  logic [StepW-1:0]   step_count;

  modport source (output valid, output people_count, output step_count, input ready);
  modport sink   (input valid, input people_count, input step_count, output ready);
endinterface

interface jeo_out_if import jeo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PeopleW-1:0] person_number;
  logic               last;

  modport source (output valid, output person_number, output last, input ready);
  modport sink   (input valid, input person_number, input last, output ready);
endinterface

// ----- hw/rtl/jeo_mod_unit.sv -----
// ----------------------------------------------------------------------------
// jeo_mod_unit
// Bit-serial restoring remainder: step modulo remaining count, one bit a cycle.
// ----------------------------------------------------------------------------
module jeo_mod_unit import jeo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [StepW-1:0]   dividend_i,
  input  logic [PeopleW-1:0] divisor_i,
  output logic               done_o,
  output logic [PeopleW-1:0] rem_o
);

  localparam int CntW = $clog2(StepW + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [StepW-1:0]   dvd_q, dvd_d;
  logic [PeopleW-1:0] div_q, div_d;
  logic [PeopleW-1:0] rem_q, rem_d;
  logic [PeopleW:0]   part;

  // partial remainder stays below the divisor, so one extra bit suffices
  assign part = {rem_q, dvd_q[StepW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(StepW);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[StepW-2:0], 1'b0};
      if (part >= {1'b0, div_q}) begin
        rem_d = PeopleW'(part - {1'b0, div_q});
      end else begin
        rem_d = PeopleW'(part);
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/jeo_ring.sv -----
// ----------------------------------------------------------------------------
// jeo_ring
// Alive mask and seat pointer; walks the circle one seat per cycle while adv is set.
// ----------------------------------------------------------------------------
module jeo_ring import jeo_pkg::*; #(
  parameter int MAX_PEOPLE = MaxPeople
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  jeo_ring_ctrl_t                ctrl_i,
  input  logic [PeopleW-1:0]            count_i,
  output logic [$clog2(MAX_PEOPLE)-1:0] seat_o,
  output logic                          alive_next_o
);

  localparam int SeatW = $clog2(MAX_PEOPLE);

  logic [MAX_PEOPLE-1:0] alive_q, alive_d;
  logic [SeatW-1:0]      seat_q, seat_d;
  logic [SeatW-1:0]      limit_q, limit_d;
  logic [SeatW-1:0]      seat_next;

  // wrap at the last seat of the circle
  assign seat_next = (seat_q == limit_q) ? '0 : seat_q + SeatW'(1);

  always_comb begin
    alive_d = alive_q;
    seat_d  = seat_q;
    limit_d = limit_q;
    if (ctrl_i.init) begin
      for (int i = 0; i < MAX_PEOPLE; i++) begin
        alive_d[i] = (PeopleW'(i) < count_i);
      end
      seat_d  = '0;
      limit_d = SeatW'(count_i - PeopleW'(1));
    end else begin
      if (ctrl_i.kill) alive_d[seat_q] = 1'b0;
      if (ctrl_i.adv)  seat_d = seat_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '0;
      seat_q  <= '0;
      limit_q <= '0;
    end else begin
      alive_q <= alive_d;
      seat_q  <= seat_d;
      limit_q <= limit_d;
    end
  end

  assign seat_o       = seat_q;
  assign alive_next_o = alive_q[seat_next];

endmodule

// ----- hw/rtl/josephus_elimination_order_unit.sv -----
// ----------------------------------------------------------------------------
// josephus_elimination_order_unit
// Emits the Josephus elimination order for a circle of people, then the
// survivor.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i takes one transfer per run: people_count (clamped to MAX_PEOPLE)
//    and step_count. in_i.ready is high only while the sequencer is idle.
//  - out_o gives one transfer per removed person, in order, then one for
//    the survivor with last set. A count of zero gives no transfer.
//  - Per removal: the sequencer passes its control states, runs the
//    bit-serial remainder unit, then walks to the victim and on to the
//    next living person. Seats are walked one per cycle through the ring.
//  - The result sits in an output register; a stalled receiver holds the
//    sequencer at the point where the next result would be loaded, and the
//    next run can be accepted while the survivor still waits.
//  - Reset clears the sequencer, the ring and the output valid.
// ----------------------------------------------------------------------------
module josephus_elimination_order_unit import jeo_pkg::*; #(
  parameter int MAX_PEOPLE = MaxPeople
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jeo_in_if.sink    in_i,
  jeo_out_if.source out_o
);

  localparam int SeatW = $clog2(MAX_PEOPLE);

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StMod   = 3'd2;
  localparam logic [2:0] StWalk  = 3'd3;
  localparam logic [2:0] StFind  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [PeopleW-1:0] remain_q, remain_d;   // people still alive
  logic [StepW-1:0]   step_q, step_d;
  logic [PeopleW-1:0] walk_q, walk_d;       // living seats still to pass

  logic               out_valid_q, out_valid_d;
  logic [PeopleW-1:0] out_num_q, out_num_d;
  logic               out_last_q, out_last_d;
  logic               out_free;
  logic               out_load;

  logic [PeopleW-1:0] count_clamped;
  logic               in_xfer;

  jeo_ring_ctrl_t     ring_ctrl;
  logic [SeatW-1:0]   seat;
  logic               alive_next;
  logic [PeopleW-1:0] seat_num;

  logic               mod_start;
  logic               mod_done;
  logic [PeopleW-1:0] mod_rem;

  assign in_xfer       = in_i.valid && in_i.ready;
  assign count_clamped = (in_i.people_count > PeopleW'(MAX_PEOPLE)) ?
                         PeopleW'(MAX_PEOPLE) : in_i.people_count;
  assign seat_num      = PeopleW'(seat) + PeopleW'(1);

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_o.ready;

  jeo_ring #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ring_ctrl),
    .count_i      (count_clamped),
    .seat_o       (seat),
    .alive_next_o (alive_next)
  );

  jeo_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (step_q),
    .divisor_i  (remain_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    state_d    = state_q;
    remain_d   = remain_q;
    step_d     = step_q;
    walk_d     = walk_q;
    ring_ctrl  = '0;
    mod_start  = 1'b0;
    out_load   = 1'b0;
    out_num_d  = out_num_q;
    out_last_d = out_last_q;

    unique case (state_q)
      StIdle: begin
        // a zero count finishes on the spot with no result
        if (in_xfer && (count_clamped != '0)) begin
          ring_ctrl.init = 1'b1;
          remain_d       = count_clamped;
          step_d         = in_i.step_count;
          state_d        = StCheck;
        end
      end
      StCheck: begin
        if (remain_q == PeopleW'(1)) begin
          // lone survivor: final result
          if (out_free) begin
            out_load   = 1'b1;
            out_num_d  = seat_num;
            out_last_d = 1'b1;
            state_d    = StIdle;
          end
        end else begin
          mod_start = 1'b1;
          state_d   = StMod;
        end
      end
      StMod: begin
        if (mod_done) begin
          // a zero remainder counts as a full lap of the living
          if (mod_rem == '0) begin
            walk_d = remain_q - PeopleW'(1);
          end else begin
            walk_d = mod_rem - PeopleW'(1);
          end
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (walk_q == '0) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_num_d      = seat_num;
            out_last_d     = 1'b0;
            ring_ctrl.kill = 1'b1;
            remain_d       = remain_q - PeopleW'(1);
            state_d        = StFind;
          end
        end else begin
          ring_ctrl.adv = 1'b1;
          if (alive_next) walk_d = walk_q - PeopleW'(1);
        end
      end
      StFind: begin
        // step to the next living seat; counting restarts there
        ring_ctrl.adv = 1'b1;
        if (alive_next) state_d = StCheck;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      remain_q    <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      remain_q    <= remain_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    out_num_q  <= out_num_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready          = (state_q == StIdle);
  assign out_o.valid         = out_valid_q;
  assign out_o.person_number = out_num_q;
  assign out_o.last          = out_last_q;

endmodule

// ----- hw/rtl/jeo_checker.sv -----
// ----------------------------------------------------------------------------
// jeo_checker
// Port-level checks for the Josephus elimination order unit.
// ----------------------------------------------------------------------------
module jeo_checker import jeo_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [PeopleW-1:0] in_people_count_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [PeopleW-1:0] out_person_number_i,
  input logic               out_last_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_person_number_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // a non-empty run keeps the input closed next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_people_count_i != '0) |=> !in_ready_i)
    else $error("input reopened during a run");

  // person numbers are one-based
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_person_number_i != '0))
    else $error("person number zero");

endmodule

bind josephus_elimination_order_unit jeo_checker u_jeo_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_people_count_i   (in_i.people_count),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_person_number_i (out_o.person_number),
  .out_last_i          (out_o.last)
);
